@@ hdl/vri_pkg.sv @@
// Shared constants, types and codes for the varispeed ring interpolator.
package vri_pkg;

  // Buffer geometry and number formats (buffer depth is a power of two)
  localparam int BUFFER_FRAMES = 65536;
  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;
  localparam int GAIN_BITS     = 16;
  localparam int PRODUCT_FRAC  = 24;

  localparam int ADDR_BITS  = $clog2(BUFFER_FRAMES);
  localparam int FILL_BITS  = ADDR_BITS + 1;
  localparam int POS_BITS   = ADDR_BITS + FRACTION_BITS;
  localparam int PROD_BITS  = 2 * GAIN_BITS;
  localparam int STEP_SHIFT = PRODUCT_FRAC - FRACTION_BITS;
  localparam int STEP_BITS  = PROD_BITS - STEP_SHIFT;
  localparam int FRAME_BITS = 2 * SAMPLE_BITS;
  localparam int DIFF_BITS  = SAMPLE_BITS + 1;
  localparam int MUL_BITS   = SAMPLE_BITS + FRACTION_BITS + 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  // Input function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH = 1'b1;
  localparam logic signed [GAIN_BITS-1:0] SPEED_RESET = 16'sd4096;
  localparam logic signed [GAIN_BITS-1:0] PITCH_RESET = 16'sd4096;

  // Decoded operation carried through the queue
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hdl/vri_if.sv @@
// Channel interfaces: input items, result items and configuration writes.
interface vri_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             func;
  logic signed [vri_pkg::SAMPLE_BITS-1:0] sample_left;
  logic signed [vri_pkg::SAMPLE_BITS-1:0] sample_right;
  logic                                   last_frame;

  modport source (output valid, func, sample_left, sample_right, last_frame, input ready);
  modport sink   (input valid, func, sample_left, sample_right, last_frame, output ready);
endinterface

interface vri_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vri_pkg::SAMPLE_BITS-1:0] out_left;
  logic signed [vri_pkg::SAMPLE_BITS-1:0] out_right;
  logic                                   batch_end;

  modport source (output valid, out_left, out_right, batch_end, input ready);
  modport sink   (input valid, out_left, out_right, batch_end, output ready);
endinterface

interface vri_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [vri_pkg::CFG_IDX_BITS-1:0]      index;
  logic [vri_pkg::GAIN_BITS-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/vri_front.sv @@
// Front end: takes input transfers, decodes the function and feeds the queue.
module vri_front (
  input  logic                 clk,
  input  logic                 rst_n,
  vri_in_if.sink               in_chan,
  input  vri_pkg::q_stat_t     q_stat,
  output logic                 q_push,
  output vri_pkg::q_entry_t    q_data
);

  logic                          fr_vld_r, fr_vld_nxt;
  logic [1:0]                    fr_func_r;
  logic signed [vri_pkg::SAMPLE_BITS-1:0] fr_left_r;
  logic signed [vri_pkg::SAMPLE_BITS-1:0] fr_right_r;
  logic                          fr_last_r;
  logic                          accept;
  logic                          consume;
  logic                          known;
  vri_pkg::op_t                  op;

  // Hold one item; it leaves once the queue has room
  assign consume       = fr_vld_r && !q_stat.full;
  assign in_chan.ready = !fr_vld_r || !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Decode function code; the unused code is dropped
  always_comb begin
    known = 1'b1;
    op    = vri_pkg::OP_WRITE;
    unique case (fr_func_r)
      vri_pkg::FUNC_WRITE: op = vri_pkg::OP_WRITE;
      vri_pkg::FUNC_READ:  op = vri_pkg::OP_READ;
      vri_pkg::FUNC_CLEAR: op = vri_pkg::OP_CLEAR;
      default:             known = 1'b0;
    endcase
  end

  assign q_push       = consume && known;
  assign q_data.op    = op;
  assign q_data.left  = fr_left_r;
  assign q_data.right = fr_right_r;
  assign q_data.last  = fr_last_r;

  always_comb begin
    fr_vld_nxt = fr_vld_r;
    if (accept) begin
      fr_vld_nxt = 1'b1;
    end else if (consume) begin
      fr_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  // Capture payload on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      fr_func_r  <= in_chan.func;
      fr_left_r  <= in_chan.sample_left;
      fr_right_r <= in_chan.sample_right;
      fr_last_r  <= in_chan.last_frame;
    end
  end

endmodule

@@ hdl/vri_queue.sv @@
// Short command queue that decouples the front end from the back end.
module vri_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  vri_pkg::q_entry_t    push_data,
  input  logic                 pop,
  output vri_pkg::q_entry_t    head,
  output vri_pkg::q_stat_t     stat
);

  vri_pkg::q_entry_t                 slot_r [vri_pkg::QUEUE_DEPTH];
  logic [vri_pkg::QPTR_BITS-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [vri_pkg::QPTR_BITS-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [vri_pkg::QCNT_BITS-1:0]     cnt_r, cnt_nxt;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == vri_pkg::QCNT_BITS'(vri_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == vri_pkg::QPTR_BITS'(vri_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == vri_pkg::QPTR_BITS'(vri_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/vri_back.sv @@
// Back end: frame store, read position, gain registers and interpolation pipeline.
module vri_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vri_pkg::q_entry_t    head,
  input  vri_pkg::q_stat_t     q_stat,
  output logic                 pop,
  vri_cfg_if.sink              cfg_chan,
  vri_out_if.source            out_chan
);

  localparam int SB = vri_pkg::SAMPLE_BITS;
  localparam int FB = vri_pkg::FRACTION_BITS;

  // Frame store: left sample in the upper half, right in the lower half
  logic [vri_pkg::FRAME_BITS-1:0] frame_mem [vri_pkg::BUFFER_FRAMES];

  logic signed [vri_pkg::GAIN_BITS-1:0] speed_r, pitch_r;
  logic signed [vri_pkg::PROD_BITS-1:0] prod_r;
  logic [vri_pkg::STEP_BITS-1:0]        step;

  logic [vri_pkg::ADDR_BITS-1:0] wr_idx_r, wr_idx_nxt;
  logic [vri_pkg::FILL_BITS-1:0] fill_r, fill_nxt;
  logic [vri_pkg::POS_BITS-1:0]  pos_r, pos_nxt;

  logic [vri_pkg::ADDR_BITS-1:0] idx0, idx1;
  logic                          adv;
  logic                          do_write, do_read, do_clear;

  // Stage 1: registered store reads
  logic                          st1_vld_r;
  logic                          st1_ok0_r, st1_ok1_r;
  logic [FB-1:0]                 st1_frac_r;
  logic                          st1_last_r;
  logic [vri_pkg::FRAME_BITS-1:0] rd0_r, rd1_r;

  // Stage 2: difference times fraction
  logic                          st2_vld_r;
  logic signed [SB-1:0]          st2_s0l_r, st2_s0r_r;
  logic signed [vri_pkg::MUL_BITS-1:0] st2_pl_r, st2_pr_r;
  logic                          st2_last_r;

  // Output register
  logic                          out_vld_r;
  logic signed [SB-1:0]          out_left_r, out_right_r;
  logic                          out_last_r;

  logic signed [SB-1:0]             s0l, s1l, s0r, s1r;
  logic signed [vri_pkg::DIFF_BITS-1:0] dl, dr;
  logic signed [vri_pkg::MUL_BITS-1:0]  ml, mr, shl, shr;
  logic signed [FB:0]               frac_s;

  // Configuration writes are always taken
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= vri_pkg::SPEED_RESET;
      pitch_r <= vri_pkg::PITCH_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        vri_pkg::CFG_SPEED: speed_r <= cfg_chan.data;
        vri_pkg::CFG_PITCH: pitch_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Read step: gain product truncated to position fraction, clamped at zero
  always_ff @(posedge clk) begin
    prod_r <= vri_pkg::PROD_BITS'(speed_r) * vri_pkg::PROD_BITS'(pitch_r);
  end

  assign step = (prod_r > 0) ? prod_r[vri_pkg::PROD_BITS-1:vri_pkg::STEP_SHIFT] : '0;

  // Whole pipeline moves unless a result waits untaken
  assign adv      = !(out_vld_r && !out_chan.ready);
  assign pop      = adv && !q_stat.empty;
  assign do_write = pop && (head.op == vri_pkg::OP_WRITE);
  assign do_read  = pop && (head.op == vri_pkg::OP_READ);
  assign do_clear = pop && (head.op == vri_pkg::OP_CLEAR);

  assign idx0 = pos_r[vri_pkg::POS_BITS-1:FB];
  assign idx1 = idx0 + 1'b1;

  // Write index, fill count and read position
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    if (do_write) begin
      wr_idx_nxt = wr_idx_r + 1'b1;
      if (fill_r != vri_pkg::FILL_BITS'(vri_pkg::BUFFER_FRAMES)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (do_read) begin
      pos_nxt = pos_r + vri_pkg::POS_BITS'(step);
    end
    if (do_clear) begin
      wr_idx_nxt = '0;
      fill_nxt   = '0;
      pos_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      fill_r   <= '0;
      pos_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // Store port: one write, two registered reads
  always_ff @(posedge clk) begin
    if (do_write) begin
      frame_mem[wr_idx_r] <= {head.left, head.right};
    end
    if (do_read) begin
      rd0_r <= frame_mem[idx0];
      rd1_r <= frame_mem[idx1];
    end
  end

  // Stage 1 side information; entries past the fill count read as zero
  always_ff @(posedge clk) begin
    if (do_read) begin
      st1_ok0_r  <= ({1'b0, idx0} < fill_r);
      st1_ok1_r  <= ({1'b0, idx1} < fill_r);
      st1_frac_r <= pos_r[FB-1:0];
      st1_last_r <= head.last;
    end
  end

  // Stage 2 arithmetic
  always_comb begin
    s0l    = st1_ok0_r ? $signed(rd0_r[vri_pkg::FRAME_BITS-1:SB]) : '0;
    s0r    = st1_ok0_r ? $signed(rd0_r[SB-1:0]) : '0;
    s1l    = st1_ok1_r ? $signed(rd1_r[vri_pkg::FRAME_BITS-1:SB]) : '0;
    s1r    = st1_ok1_r ? $signed(rd1_r[SB-1:0]) : '0;
    dl     = {s1l[SB-1], s1l} - {s0l[SB-1], s0l};
    dr     = {s1r[SB-1], s1r} - {s0r[SB-1], s0r};
    frac_s = $signed({1'b0, st1_frac_r});
    ml     = vri_pkg::MUL_BITS'(dl) * vri_pkg::MUL_BITS'(frac_s);
    mr     = vri_pkg::MUL_BITS'(dr) * vri_pkg::MUL_BITS'(frac_s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st2_s0l_r  <= s0l;
      st2_s0r_r  <= s0r;
      st2_pl_r   <= ml;
      st2_pr_r   <= mr;
      st2_last_r <= st1_last_r;
    end
  end

  // Output: base sample plus floored fractional part of the difference
  assign shl = st2_pl_r >>> FB;
  assign shr = st2_pr_r >>> FB;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_r  <= st2_s0l_r + shl[SB-1:0];
      out_right_r <= st2_s0r_r + shr[SB-1:0];
      out_last_r  <= st2_last_r;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
      st2_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      st1_vld_r <= do_read;
      st2_vld_r <= st1_vld_r;
      out_vld_r <= st2_vld_r;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_left  = out_left_r;
  assign out_chan.out_right = out_right_r;
  assign out_chan.batch_end = out_last_r;

endmodule

@@ hdl/varispeed_ring_interpolator.sv @@
// Path: a read transfer's result passes the front register, the queue, the registered
// store read, the multiply register and the output register before it shows.
// Throughput: one item per cycle; the back end's single issue slot and the
// store's one write and two read ports set that figure; output stalls hold the pipeline.
// Reset: synchronous active-low rst_n; the store reads as zero through a fill
// count, so no clearing pass is needed and items are taken right after reset.
module varispeed_ring_interpolator (
  input  logic       clk,
  input  logic       rst_n,
  vri_in_if.sink     in_chan,
  vri_out_if.source  out_chan,
  vri_cfg_if.sink    cfg_chan
);

  logic              q_push;
  logic              q_pop;
  vri_pkg::q_entry_t q_in;
  vri_pkg::q_entry_t q_head;
  vri_pkg::q_stat_t  q_stat;

  // Accept and decode
  vri_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  // Decouple front and back
  vri_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Execute against the frame store
  vri_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the varispeed ring interpolator: directed, sweep and random items.
module testbench;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_PAUSE = 12;
  localparam int IDLE_PCT = 19;
  localparam longint TIMEOUT = 1_000_000;

  localparam logic signed [vri_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [vri_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic signed [vri_pkg::GAIN_BITS-1:0] GAIN_MAX = 16'sh7FFF;
  localparam logic signed [vri_pkg::GAIN_BITS-1:0] GAIN_MIN = 16'sh8000;
  localparam logic signed [vri_pkg::GAIN_BITS-1:0] GAIN_ONE = 16'sd4096;

  typedef struct {
    logic signed [vri_pkg::SAMPLE_BITS-1:0] left;
    logic signed [vri_pkg::SAMPLE_BITS-1:0] right;
    logic                                   last;
  } lerp_frame_t;

  logic clk;
  logic rst_n;

  vri_in_if  in_if ();
  vri_out_if out_if ();
  vri_cfg_if cfg_if ();

  varispeed_ring_interpolator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Shadow copy of the ring, positions and gains
  logic signed [vri_pkg::SAMPLE_BITS-1:0] left_ring  [vri_pkg::BUFFER_FRAMES];
  logic signed [vri_pkg::SAMPLE_BITS-1:0] right_ring [vri_pkg::BUFFER_FRAMES];
  logic [vri_pkg::ADDR_BITS-1:0]          wr_ptr;
  logic [vri_pkg::POS_BITS-1:0]           rd_pos;
  logic signed [vri_pkg::GAIN_BITS-1:0]   speed_q;
  logic signed [vri_pkg::GAIN_BITS-1:0]   pitch_q;
  lerp_frame_t                            lerp_frames [$];

  int mismatch_count = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Zero both stores and both positions
  function automatic void ring_wipe();
    for (int k = 0; k < vri_pkg::BUFFER_FRAMES; k++) begin
      left_ring[k]  = '0;
      right_ring[k] = '0;
    end
    wr_ptr = '0;
    rd_pos = '0;
  endfunction

  // Read step in 16.16 frames from the current gains, clamped at zero
  function automatic logic [vri_pkg::POS_BITS-1:0] gain_step();
    longint prod;
    prod = longint'(speed_q) * longint'(pitch_q);
    if (prod <= 0) return '0;
    prod = prod >>> vri_pkg::STEP_SHIFT;
    return prod[vri_pkg::POS_BITS-1:0];
  endfunction

  // Linear blend a + floor((b - a) * fr / 2^FRACTION_BITS)
  function automatic logic signed [vri_pkg::SAMPLE_BITS-1:0] blend(
    input logic signed [vri_pkg::SAMPLE_BITS-1:0] a,
    input logic signed [vri_pkg::SAMPLE_BITS-1:0] b,
    input logic [vri_pkg::FRACTION_BITS-1:0]      fr
  );
    longint span;
    longint prod;
    longint mix;
    span = longint'(b) - longint'(a);
    prod = span * longint'(fr);
    mix  = longint'(a) + (prod >>> vri_pkg::FRACTION_BITS);
    return mix[vri_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Apply one accepted item to the shadow ring, queue the frame a read yields
  function automatic void ring_track(
    input logic [1:0]                             func,
    input logic signed [vri_pkg::SAMPLE_BITS-1:0] left,
    input logic signed [vri_pkg::SAMPLE_BITS-1:0] right,
    input logic                                   last
  );
    lerp_frame_t                   frame;
    logic [vri_pkg::ADDR_BITS-1:0] i0;
    logic [vri_pkg::ADDR_BITS-1:0] i1;
    logic [vri_pkg::FRACTION_BITS-1:0] fr;
    case (func)
      vri_pkg::FUNC_WRITE: begin
        left_ring[wr_ptr]  = left;
        right_ring[wr_ptr] = right;
        wr_ptr = wr_ptr + 1'b1;
      end
      vri_pkg::FUNC_READ: begin
        i0 = rd_pos[vri_pkg::POS_BITS-1:vri_pkg::FRACTION_BITS];
        i1 = i0 + 1'b1;
        fr = rd_pos[vri_pkg::FRACTION_BITS-1:0];
        frame.left  = blend(left_ring[i0], left_ring[i1], fr);
        frame.right = blend(right_ring[i0], right_ring[i1], fr);
        frame.last  = last;
        lerp_frames.push_back(frame);
        rd_pos = rd_pos + gain_step();
      end
      vri_pkg::FUNC_CLEAR: ring_wipe();
      default: ;
    endcase
  endfunction

  // Offer one item, sometimes after a random gap, and hold it until the transfer
  task automatic send_item(
    input logic [1:0]                             func,
    input logic signed [vri_pkg::SAMPLE_BITS-1:0] left,
    input logic signed [vri_pkg::SAMPLE_BITS-1:0] right,
    input logic                                   last
  );
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= func;
    in_if.sample_left  <= left;
    in_if.sample_right <= right;
    in_if.last_frame   <= last;
    do @(posedge clk); while (!in_if.ready);
    ring_track(func, left, right, last);
  endtask

  // Item of the given function with random samples and batch flag
  task automatic send_frame(input logic [1:0] func);
    logic [31:0] l;
    logic [31:0] r;
    l = $urandom;
    r = $urandom;
    send_item(func, l[vri_pkg::SAMPLE_BITS-1:0], r[vri_pkg::SAMPLE_BITS-1:0], r[31]);
  endtask

  // Mostly writes and reads, with rare clears and unused codes
  task automatic send_random(input int write_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < write_pct) send_frame(vri_pkg::FUNC_WRITE);
    else if (pick < 95) send_frame(vri_pkg::FUNC_READ);
    else if (pick < 97) send_frame(vri_pkg::FUNC_CLEAR);
    else send_frame(FUNC_SPARE);
  endtask

  // Drop valid, wait for every pending frame, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (lerp_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vri_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [vri_pkg::GAIN_BITS-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == vri_pkg::CFG_SPEED) speed_q = val;
    else pitch_q = val;
  endtask

  task automatic set_gains(input logic signed [vri_pkg::GAIN_BITS-1:0] speed, pitch);
    write_reg(vri_pkg::CFG_SPEED, speed);
    write_reg(vri_pkg::CFG_PITCH, pitch);
    cfg_if.valid <= 1'b0;
  endtask

  // Extremes, unused code, clear, unit and half steps
  task automatic test_directed();
    send_item(vri_pkg::FUNC_WRITE, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_item(vri_pkg::FUNC_WRITE, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_item(vri_pkg::FUNC_READ, '0, '0, 1'b1);
    settle();
    set_gains(GAIN_ONE, 16'sd2048);
    send_item(vri_pkg::FUNC_WRITE, '0, '1, 1'b0);
    send_item(vri_pkg::FUNC_WRITE, '1, '0, 1'b0);
    send_item(FUNC_SPARE, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_item(FUNC_SPARE, '0, '0, 1'b0);
    for (int k = 0; k < 6; k++) send_item(vri_pkg::FUNC_READ, SAMPLE_MIN, SAMPLE_MAX, k[0]);
    send_item(vri_pkg::FUNC_CLEAR, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_item(vri_pkg::FUNC_READ, '0, '0, 1'b1);
    send_item(vri_pkg::FUNC_WRITE, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_item(vri_pkg::FUNC_READ, '1, '1, 1'b0);
    send_item(vri_pkg::FUNC_READ, '0, '0, 1'b1);
  endtask

  task automatic sweep_point(input logic signed [vri_pkg::GAIN_BITS-1:0] speed, pitch);
    settle();
    set_gains(speed, pitch);
    send_frame(vri_pkg::FUNC_CLEAR);
    repeat (6) send_frame(vri_pkg::FUNC_WRITE);
    repeat (8) send_frame(vri_pkg::FUNC_READ);
  endtask

  // Largest steps, negative and zero products, smallest nonzero step
  task automatic test_step_sweep();
    sweep_point(GAIN_MAX, GAIN_MAX);
    sweep_point(GAIN_MIN, GAIN_MIN);
    sweep_point(GAIN_MIN, GAIN_MAX);
    sweep_point(GAIN_MAX, GAIN_MIN);
    sweep_point(16'sd0, 16'sd0);
    sweep_point(16'sd1, 16'sd1);
    sweep_point(16'sd1, 16'sd256);
    sweep_point(-16'sd1, -16'sd256);
    sweep_point(GAIN_ONE, GAIN_ONE);
  endtask

  // Fill 64 entries, then read at 64 frames a step from 63.5 so one read
  // straddles the last written entry and the first unwritten one
  task automatic test_ring_wrap();
    settle();
    set_gains(GAIN_MIN, 16'sh8100);
    send_frame(vri_pkg::FUNC_CLEAR);
    repeat (64) send_frame(vri_pkg::FUNC_WRITE);
    send_frame(vri_pkg::FUNC_READ);
    settle();
    set_gains(GAIN_MIN, GAIN_MIN);
    repeat (8) send_frame(vri_pkg::FUNC_READ);
  endtask

  // Hold off the result side long enough to fill the block
  task automatic test_backpressure();
    settle();
    set_gains(GAIN_ONE, GAIN_ONE);
    hold_req++;
    repeat (16) send_frame(vri_pkg::FUNC_WRITE);
    repeat (40) send_frame(vri_pkg::FUNC_READ);
  endtask

  // No gaps on either side for a long stretch
  task automatic test_full_rate();
    settle();
    set_gains(GAIN_ONE, 16'sd6144);
    no_idle = 1'b1;
    repeat (180) send_random(50);
    settle();
    no_idle = 1'b0;
  endtask

  // Phases of random items under random gains, mostly modest steps
  task automatic test_random();
    logic [31:0] g1;
    logic [31:0] g2;
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      if ($urandom_range(99) < 70) begin
        g1 = $urandom_range(8192, 2048);
        g2 = $urandom_range(8192, 2048);
      end else begin
        g1 = $urandom;
        g2 = $urandom;
      end
      set_gains(g1[vri_pkg::GAIN_BITS-1:0], g2[vri_pkg::GAIN_BITS-1:0]);
      repeat (80) send_random(48);
    end
  endtask

  // Result side ready: random stalls, a counted hold-off, or always ready
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (no_idle) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result transfer with the oldest pending frame
  always @(posedge clk) begin : result_check
    lerp_frame_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (lerp_frames.size() == 0) begin
        $display("%0t: result with none pending: left %0d right %0d batch_end %0b",
                 $time, out_if.out_left, out_if.out_right, out_if.batch_end);
        mismatch_count++;
      end else begin
        want = lerp_frames.pop_front();
        if (out_if.out_left !== want.left) begin
          $display("%0t: out_left expected %0d actual %0d", $time, want.left, out_if.out_left);
          mismatch_count++;
        end
        if (out_if.out_right !== want.right) begin
          $display("%0t: out_right expected %0d actual %0d",
                   $time, want.right, out_if.out_right);
          mismatch_count++;
        end
        if (out_if.batch_end !== want.last) begin
          $display("%0t: batch_end expected %0b actual %0b",
                   $time, want.last, out_if.batch_end);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.func          = vri_pkg::FUNC_WRITE;
    in_if.sample_left   = '0;
    in_if.sample_right  = '0;
    in_if.last_frame    = 1'b0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = vri_pkg::CFG_SPEED;
    cfg_if.data         = '0;
    ring_wipe();
    speed_q = vri_pkg::SPEED_RESET;
    pitch_q = vri_pkg::PITCH_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_step_sweep();
    test_ring_wrap();
    test_backpressure();
    test_full_rate();
    test_random();
    settle();

    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT);
    $display("testbench: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/vri_pkg.sv
hdl/vri_if.sv
hdl/vri_front.sv
hdl/vri_queue.sv
hdl/vri_back.sv
hdl/varispeed_ring_interpolator.sv
tb/testbench.sv
